// ----- rtl/core/assert_macros.svh -----
// assertion macros used by idle_power_save_scheduler_core
// needs a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/ipss_pkg.sv -----
// types, constants and helpers of the idle power-save scheduler
// no dependencies
package ipss_pkg;

  // timing constants
  localparam int unsigned TICKS_PER_HOUR = 36000;
  localparam int unsigned WEEK_HOURS     = 168;
  localparam int unsigned TEMP_LOW       = 24;
  localparam int unsigned TEMP_HIGH      = 32;
  localparam int unsigned FEW_SPELLS     = 2;
  localparam int unsigned MANY_SPELLS    = 4;
  localparam int unsigned HM_SCALE       = 100;

  localparam int TICK_W  = 16;
  localparam int HOUR_W  = 8;
  localparam int HM_W    = 12;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // register map, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_SLEEP_ENABLE        = 3'd0,
    REG_SLEEP_START_HOUR    = 3'd1,
    REG_SLEEP_START_MINUTE  = 3'd2,
    REG_SLEEP_END_HOUR      = 3'd3,
    REG_SLEEP_END_MINUTE    = 3'd4,
    REG_IDLE_SAVE_HOURS     = 3'd5,
    REG_LONG_IDLE_HOURS     = 3'd6,
    REG_DISPLAY_SLEEP_TICKS = 3'd7
  } reg_idx_t;

  // register reset values
  localparam logic [4:0]  RST_SLEEP_START_HOUR    = 5'd22;
  localparam logic [5:0]  RST_SLEEP_START_MINUTE  = 6'd0;
  localparam logic [4:0]  RST_SLEEP_END_HOUR      = 5'd7;
  localparam logic [5:0]  RST_SLEEP_END_MINUTE    = 6'd0;
  localparam logic [7:0]  RST_IDLE_SAVE_HOURS     = 8'd9;
  localparam logic [7:0]  RST_LONG_IDLE_HOURS     = 8'd16;
  localparam logic [15:0] RST_DISPLAY_SLEEP_TICKS = 16'd600;

  // one tick item
  typedef struct packed {
    logic       touch;
    logic       test_toggle;
    logic       feature_enable;
    logic [7:0] ambient_temp;
    logic [4:0] clock_hour;
    logic [5:0] clock_minute;
    logic       on_main_screen;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic idle_save_active;
    logic busy_week;
    logic normal_use;
    logic sleep_active;
    logic display_sleep;
  } out_item_t;

  // time of day as hour*100+minute
  function automatic logic [HM_W-1:0] hm_value(input logic [4:0] hour,
                                               input logic [5:0] minute);
    logic [HM_W-1:0] prod;
    prod = HM_W'(hour) * HM_W'(HM_SCALE);
    return prod + HM_W'(minute);
  endfunction

endpackage

// ----- rtl/core/idle_power_save_scheduler_core.sv -----
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_data  (in_item_t)
//  out_    | output    | out_valid/out_stall| out_data (out_item_t)
//  cfg     | apb write | psel/penable/pwrite| paddr, pwdata, prdata
//
// one item per cycle sustained while out_stall is low; an item is held in the input
// register and its result is registered into the output register.
// the state update is a single short pass of counters and compares.
// rst_n (synchronous) returns all counters, flags, valid bits and configuration registers to reset values;
// the payload registers are not reset. a stalled result holds the output register; the input register then fills
// and in_stall rises only when both registers are occupied.
//
// idle power-save scheduler core: tick timers, weekly mode and sleep window
// depends on ipss_pkg and assert_macros.svh
`include "assert_macros.svh"

module idle_power_save_scheduler_core
  import ipss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // configuration registers
  logic        sleep_enable_r;
  logic [4:0]  sleep_start_hour_r;
  logic [5:0]  sleep_start_minute_r;
  logic [4:0]  sleep_end_hour_r;
  logic [5:0]  sleep_end_minute_r;
  logic [7:0]  idle_save_hours_r;
  logic [7:0]  long_idle_hours_r;
  logic [15:0] display_sleep_ticks_r;

  // pipeline registers
  logic      in_valid_r;
  in_item_t  in_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;

  // scheduler state
  logic [TICK_W-1:0] idle_tick_count_r,  idle_tick_count_nxt;
  logic [HOUR_W-1:0] idle_hour_count_r,  idle_hour_count_nxt;
  logic              idle_save_flag_r,   idle_save_flag_nxt;
  logic [TICK_W-1:0] learn_tick_count_r, learn_tick_count_nxt;
  logic [HOUR_W-1:0] unused_hour_count_r, unused_hour_count_nxt;
  logic [HOUR_W-1:0] week_hour_count_r,  week_hour_count_nxt;
  logic [HOUR_W-1:0] long_idle_spells_r, long_idle_spells_nxt;
  logic              week_elapsed_r,     week_elapsed_nxt;
  logic              mode_intensive_r,   mode_intensive_nxt;
  logic              normal_use_flag_r,  normal_use_flag_nxt;
  logic              touch_pending_r,    touch_pending_nxt;
  logic              test_hold_r,        test_hold_nxt;
  logic              sleep_flag_r,       sleep_flag_nxt;
  logic              display_sleep_flag_r, display_sleep_flag_nxt;
  logic [TICK_W-1:0] display_tick_count_r, display_tick_count_nxt;

  out_item_t result;
  logic      advance;
  logic      cfg_write;
  reg_idx_t  cfg_idx;

  // handshake: the result register frees when empty or taken
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // apb access
  assign pready    = 1'b1;
  assign cfg_idx   = reg_idx_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_idx)
      REG_SLEEP_ENABLE:        prdata = DATA_W'(sleep_enable_r);
      REG_SLEEP_START_HOUR:    prdata = DATA_W'(sleep_start_hour_r);
      REG_SLEEP_START_MINUTE:  prdata = DATA_W'(sleep_start_minute_r);
      REG_SLEEP_END_HOUR:      prdata = DATA_W'(sleep_end_hour_r);
      REG_SLEEP_END_MINUTE:    prdata = DATA_W'(sleep_end_minute_r);
      REG_IDLE_SAVE_HOURS:     prdata = DATA_W'(idle_save_hours_r);
      REG_LONG_IDLE_HOURS:     prdata = DATA_W'(long_idle_hours_r);
      REG_DISPLAY_SLEEP_TICKS: prdata = DATA_W'(display_sleep_ticks_r);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sleep_enable_r        <= 1'b0;
      sleep_start_hour_r    <= RST_SLEEP_START_HOUR;
      sleep_start_minute_r  <= RST_SLEEP_START_MINUTE;
      sleep_end_hour_r      <= RST_SLEEP_END_HOUR;
      sleep_end_minute_r    <= RST_SLEEP_END_MINUTE;
      idle_save_hours_r     <= RST_IDLE_SAVE_HOURS;
      long_idle_hours_r     <= RST_LONG_IDLE_HOURS;
      display_sleep_ticks_r <= RST_DISPLAY_SLEEP_TICKS;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_SLEEP_ENABLE:        sleep_enable_r        <= pwdata[0];
        REG_SLEEP_START_HOUR:    sleep_start_hour_r    <= pwdata[4:0];
        REG_SLEEP_START_MINUTE:  sleep_start_minute_r  <= pwdata[5:0];
        REG_SLEEP_END_HOUR:      sleep_end_hour_r      <= pwdata[4:0];
        REG_SLEEP_END_MINUTE:    sleep_end_minute_r    <= pwdata[5:0];
        REG_IDLE_SAVE_HOURS:     idle_save_hours_r     <= pwdata[7:0];
        REG_LONG_IDLE_HOURS:     long_idle_hours_r     <= pwdata[7:0];
        REG_DISPLAY_SLEEP_TICKS: display_sleep_ticks_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // one tick: test key, touch, weekly mode, idle timers, sleep window
  always_comb begin
    logic [HM_W-1:0]   now_hm, start_hm, end_hm;
    logic              in_window;
    logic [HOUR_W:0]   spells_inc;
    logic [TICK_W:0]   disp_inc;

    idle_tick_count_nxt    = idle_tick_count_r;
    idle_hour_count_nxt    = idle_hour_count_r;
    idle_save_flag_nxt     = idle_save_flag_r;
    learn_tick_count_nxt   = learn_tick_count_r;
    unused_hour_count_nxt  = unused_hour_count_r;
    week_hour_count_nxt    = week_hour_count_r;
    long_idle_spells_nxt   = long_idle_spells_r;
    week_elapsed_nxt       = week_elapsed_r;
    mode_intensive_nxt     = mode_intensive_r;
    normal_use_flag_nxt    = normal_use_flag_r;
    touch_pending_nxt      = touch_pending_r;
    test_hold_nxt          = test_hold_r;
    sleep_flag_nxt         = sleep_flag_r;
    display_sleep_flag_nxt = display_sleep_flag_r;
    display_tick_count_nxt = display_tick_count_r;

    // test key flips the forced hold
    if (in_data_r.test_toggle) begin
      test_hold_nxt       = !test_hold_r;
      normal_use_flag_nxt = !test_hold_r;
    end

    // touch wakes the display and restarts idle timing
    if (in_data_r.touch) begin
      display_sleep_flag_nxt = 1'b0;
      display_tick_count_nxt = '0;
      touch_pending_nxt      = 1'b1;
      idle_tick_count_nxt    = '0;
      idle_hour_count_nxt    = '0;
      idle_save_flag_nxt     = 1'b0;
    end

    // weekly learned mode
    spells_inc = {1'b0, long_idle_spells_nxt} + 1'b1;
    if (week_elapsed_nxt) begin
      if (!mode_intensive_nxt) begin
        mode_intensive_nxt = (long_idle_spells_nxt <= HOUR_W'(FEW_SPELLS));
      end else begin
        mode_intensive_nxt = !(long_idle_spells_nxt >= HOUR_W'(MANY_SPELLS));
      end
      week_elapsed_nxt      = 1'b0;
      long_idle_spells_nxt  = '0;
      learn_tick_count_nxt  = '0;
      unused_hour_count_nxt = '0;
      week_hour_count_nxt   = '0;
      idle_tick_count_nxt   = '0;
      idle_hour_count_nxt   = '0;
      idle_save_flag_nxt    = 1'b0;
    end else if (touch_pending_nxt) begin
      if (unused_hour_count_nxt >= long_idle_hours_r) begin
        if (spells_inc >= (HOUR_W+1)'(WEEK_HOURS)) begin
          long_idle_spells_nxt = HOUR_W'(WEEK_HOURS);
        end else begin
          long_idle_spells_nxt = spells_inc[HOUR_W-1:0];
        end
      end
      learn_tick_count_nxt  = '0;
      unused_hour_count_nxt = '0;
      touch_pending_nxt     = 1'b0;
    end
    normal_use_flag_nxt = mode_intensive_nxt;
    if (mode_intensive_nxt) begin
      idle_tick_count_nxt = '0;
      idle_hour_count_nxt = '0;
      idle_save_flag_nxt  = 1'b0;
    end

    // idle and learning timers
    if (test_hold_nxt || !in_data_r.feature_enable) begin
      idle_tick_count_nxt   = '0;
      idle_hour_count_nxt   = '0;
      idle_save_flag_nxt    = 1'b0;
      week_elapsed_nxt      = 1'b0;
      long_idle_spells_nxt  = '0;
      week_hour_count_nxt   = '0;
      learn_tick_count_nxt  = '0;
      unused_hour_count_nxt = '0;
      mode_intensive_nxt    = 1'b0;
    end else begin
      idle_tick_count_nxt = idle_tick_count_nxt + 1'b1;
      if (idle_tick_count_nxt >= TICK_W'(TICKS_PER_HOUR)) begin
        idle_tick_count_nxt = '0;
        idle_hour_count_nxt = idle_hour_count_nxt + 1'b1;
      end
      if (idle_hour_count_nxt >= idle_save_hours_r) begin
        idle_save_flag_nxt = !normal_use_flag_nxt;
      end
      learn_tick_count_nxt = learn_tick_count_nxt + 1'b1;
      if (learn_tick_count_nxt >= TICK_W'(TICKS_PER_HOUR)) begin
        learn_tick_count_nxt  = '0;
        unused_hour_count_nxt = unused_hour_count_nxt + 1'b1;
        week_hour_count_nxt   = week_hour_count_nxt + 1'b1;
      end
      if (week_hour_count_nxt >= HOUR_W'(WEEK_HOURS)) begin
        week_hour_count_nxt = '0;
        week_elapsed_nxt    = 1'b1;
      end
      if (in_data_r.ambient_temp < 8'(TEMP_LOW) || in_data_r.ambient_temp > 8'(TEMP_HIGH)) begin
        idle_tick_count_nxt = '0;
        idle_hour_count_nxt = '0;
        idle_save_flag_nxt  = 1'b0;
      end
    end

    // sleep window, may wrap past midnight
    now_hm   = hm_value(in_data_r.clock_hour, in_data_r.clock_minute);
    start_hm = hm_value(sleep_start_hour_r, sleep_start_minute_r);
    end_hm   = hm_value(sleep_end_hour_r, sleep_end_minute_r);
    if (start_hm > end_hm) begin
      in_window = (now_hm >= start_hm) || (now_hm < end_hm);
    end else if (start_hm < end_hm) begin
      in_window = (now_hm >= start_hm) && (now_hm < end_hm);
    end else begin
      in_window = 1'b0;
    end

    disp_inc = '0;
    if (!sleep_enable_r) begin
      sleep_flag_nxt         = 1'b0;
      display_sleep_flag_nxt = 1'b0;
      display_tick_count_nxt = '0;
    end else begin
      if (!sleep_flag_nxt) begin
        if (in_window) begin
          sleep_flag_nxt = 1'b1;
          if (in_data_r.on_main_screen) begin
            display_sleep_flag_nxt = 1'b1;
          end
        end
      end else if (!in_window) begin
        sleep_flag_nxt = 1'b0;
        if (start_hm != end_hm) begin
          idle_tick_count_nxt = '0;
          idle_hour_count_nxt = '0;
          idle_save_flag_nxt  = 1'b0;
        end
      end
      // delayed display sleep, count saturates at the programmed delay
      if (sleep_flag_nxt) begin
        disp_inc = {1'b0, display_tick_count_nxt} + 1'b1;
        if (disp_inc >= {1'b0, display_sleep_ticks_r}) begin
          display_tick_count_nxt = display_sleep_ticks_r;
          if (in_data_r.on_main_screen) begin
            display_sleep_flag_nxt = 1'b1;
          end
        end else begin
          display_tick_count_nxt = disp_inc[TICK_W-1:0];
        end
      end else begin
        display_sleep_flag_nxt = 1'b0;
        display_tick_count_nxt = '0;
      end
    end

    result.idle_save_active = idle_save_flag_nxt;
    result.busy_week        = mode_intensive_nxt;
    result.normal_use       = normal_use_flag_nxt;
    result.sleep_active     = sleep_flag_nxt;
    result.display_sleep    = display_sleep_flag_nxt;
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r           <= 1'b0;
      out_valid_r          <= 1'b0;
      idle_tick_count_r    <= '0;
      idle_hour_count_r    <= '0;
      idle_save_flag_r     <= 1'b0;
      learn_tick_count_r   <= '0;
      unused_hour_count_r  <= '0;
      week_hour_count_r    <= '0;
      long_idle_spells_r   <= '0;
      week_elapsed_r       <= 1'b0;
      mode_intensive_r     <= 1'b0;
      normal_use_flag_r    <= 1'b0;
      touch_pending_r      <= 1'b0;
      test_hold_r          <= 1'b0;
      sleep_flag_r         <= 1'b0;
      display_sleep_flag_r <= 1'b0;
      display_tick_count_r <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        idle_tick_count_r    <= idle_tick_count_nxt;
        idle_hour_count_r    <= idle_hour_count_nxt;
        idle_save_flag_r     <= idle_save_flag_nxt;
        learn_tick_count_r   <= learn_tick_count_nxt;
        unused_hour_count_r  <= unused_hour_count_nxt;
        week_hour_count_r    <= week_hour_count_nxt;
        long_idle_spells_r   <= long_idle_spells_nxt;
        week_elapsed_r       <= week_elapsed_nxt;
        mode_intensive_r     <= mode_intensive_nxt;
        normal_use_flag_r    <= normal_use_flag_nxt;
        touch_pending_r      <= touch_pending_nxt;
        test_hold_r          <= test_hold_nxt;
        sleep_flag_r         <= sleep_flag_nxt;
        display_sleep_flag_r <= display_sleep_flag_nxt;
        display_tick_count_r <= display_tick_count_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  // checks
  `ASSERT_IMPL(a_disp_needs_sleep, out_valid_r && out_data_r.display_sleep, out_data_r.sleep_active)
  `ASSERT_IMPL(a_save_not_normal, out_valid_r && out_data_r.idle_save_active, !out_data_r.normal_use)
  `ASSERT_IMPL(a_idle_tick_range, 1'b1, idle_tick_count_r < TICK_W'(TICKS_PER_HOUR))
  `ASSERT_IMPL(a_week_hour_range, 1'b1, week_hour_count_r < HOUR_W'(WEEK_HOURS))
  `ASSERT_NEXT(a_spells_sat, 1'b1, long_idle_spells_r <= HOUR_W'(WEEK_HOURS))

endmodule
